// ===== sv/bmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmmc_pkg
// shared types, address map constants and codes for the banked memory map
// controller
// ----------------------------------------------------------------------------
`default_nettype none

package bmmc_pkg;

  // default sizes
  localparam int CART_RAM_BYTES_DEF = 32768;
  localparam int DMA_LENGTH_DEF     = 160;
  localparam int QUEUE_DEPTH        = 2;
  localparam int MAP_BYTES          = 65536;

  // bus address map
  localparam logic [15:0] ADDR_RAM_EN_HI  = 16'h1FFF;
  localparam logic [15:0] ADDR_ROM0_HI    = 16'h3FFF;
  localparam logic [15:0] ADDR_UPPER_HI   = 16'h5FFF;
  localparam logic [15:0] ADDR_ROM_HI     = 16'h7FFF;
  localparam logic [15:0] ADDR_CART_LO    = 16'hA000;
  localparam logic [15:0] ADDR_CART_HI    = 16'hBFFF;
  localparam logic [15:0] ADDR_ECHO_LO_LO = 16'hC000;
  localparam logic [15:0] ADDR_ECHO_LO_HI = 16'hDE00;
  localparam logic [15:0] ADDR_ECHO_HI_LO = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_HI_HI = 16'hFE00;
  localparam logic [15:0] ADDR_DIV        = 16'hFF04;
  localparam logic [15:0] ADDR_LY         = 16'hFF44;
  localparam logic [15:0] ADDR_DMA        = 16'hFF46;
  localparam logic [15:0] DMA_DEST        = 16'hFE00;
  localparam logic [15:0] ECHO_OFFSET     = 16'h2000;

  localparam logic [3:0]  RAM_EN_KEY      = 4'hA;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_fetch;
    logic [21:0] rom_address;
  } out_item_t;

  // work for the back end, as classified by the front end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ROM,
    OP_MEM_RD,
    OP_CART_RD,
    OP_MEM_WR,
    OP_CART_WR,
    OP_ECHO_WR,
    OP_DMA
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] addr_a;
    logic [15:0] addr_b;
    logic [7:0]  data;
    logic [21:0] rom_address;
  } q_entry_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_ECHO,
    BK_DMA
  } back_state_t;

endpackage : bmmc_pkg

`default_nettype wire

// ===== sv/banked_memory_map_controller.sv =====
// ----------------------------------------------------------------------------
// banked_memory_map_controller
// banked cartridge mapper with a flat 64 KiB mapped memory and oam dma copy
// ----------------------------------------------------------------------------
// path: an input transfer is queued, then the back end loads the result
//   register; reads and echoed writes also pass through BK_READ or BK_ECHO
// throughput: one item a cycle while out_ready is high; no new item is taken
//   in BK_READ or BK_ECHO (registered ram read, one write port) or BK_DMA
// reset: both memories swept to zero with in_ready low; banking registers
//   reset to rom bank 1, ram bank 0
`default_nettype none

module banked_memory_map_controller
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BYTES = CART_RAM_BYTES_DEF,
  parameter int DMA_LENGTH     = DMA_LENGTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // front to queue
  logic     q_push;
  q_entry_t q_push_entry;
  logic     q_full;

  // queue to back
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head_entry;

  // back end still sweeping the memories after reset
  logic     clr_busy;

  // front end: takes the transfer, updates the banking registers and works
  // out the rom address or the cartridge ram index with the bank in force
  bmmc_front #(
    .CART_RAM_BYTES (CART_RAM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  // decouples the two sides so a long dma copy does not block the bus
  // until the queue fills
  bmmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  // back end: memory accesses in order, output register for the result
  bmmc_back #(
    .CART_RAM_BYTES (CART_RAM_BYTES),
    .DMA_LENGTH     (DMA_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_entry   (q_head_entry),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : banked_memory_map_controller

`default_nettype wire

// ===== sv/bmmc_ram.sv =====
// ----------------------------------------------------------------------------
// bmmc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bmmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : bmmc_ram

`default_nettype wire

// ===== sv/bmmc_front.sv =====
// ----------------------------------------------------------------------------
// bmmc_front
// accepts bus accesses, keeps the banking registers and classifies work
// ----------------------------------------------------------------------------
`default_nettype none

module bmmc_front
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BYTES = CART_RAM_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  input  wire logic     clr_busy,
  output logic          q_push,
  output q_entry_t      q_entry
);

  localparam logic [16:0] LIM1 = 17'(CART_RAM_BYTES);
  localparam logic [16:0] LIM2 = 17'(2 * CART_RAM_BYTES);
  localparam logic [16:0] LIM3 = 17'(3 * CART_RAM_BYTES);

  logic [7:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;
  logic       ram_enable_r, ram_enable_nxt;
  logic       banking_mode_r, banking_mode_nxt;

  logic [15:0] addr;
  logic [7:0]  data;
  logic [16:0] cart_raw;
  logic [16:0] cart_idx;

  assign addr     = in_data.address;
  assign data     = in_data.write_data;
  assign in_ready = !q_full && !clr_busy;
  assign q_push   = in_valid && in_ready;

  // banked offset, folded into the cartridge ram size
  assign cart_raw = {2'b00, ram_bank_r, addr[12:0]};

  always_comb begin
    if (cart_raw >= LIM3) begin
      cart_idx = cart_raw - LIM3;
    end else if (cart_raw >= LIM2) begin
      cart_idx = cart_raw - LIM2;
    end else if (cart_raw >= LIM1) begin
      cart_idx = cart_raw - LIM1;
    end else begin
      cart_idx = cart_raw;
    end
  end

  always_comb begin
    q_entry          = '0;
    q_entry.kind     = OP_NOP;
    q_entry.addr_a   = addr;
    q_entry.data     = data;
    rom_bank_nxt     = rom_bank_r;
    ram_bank_nxt     = ram_bank_r;
    ram_enable_nxt   = ram_enable_r;
    banking_mode_nxt = banking_mode_r;
    if (in_data.cmd == CMD_WRITE) begin
      if (addr <= ADDR_RAM_EN_HI) begin
        ram_enable_nxt = (data[3:0] == RAM_EN_KEY);
      end else if (addr <= ADDR_ROM0_HI) begin
        rom_bank_nxt = (data == 8'd0) ? 8'd1 : data;
      end else if (addr <= ADDR_UPPER_HI) begin
        if (banking_mode_r) begin
          ram_bank_nxt = data[1:0];
        end else begin
          rom_bank_nxt = rom_bank_r | {1'b0, data[1:0], 5'b00000};
        end
      end else if (addr <= ADDR_ROM_HI) begin
        banking_mode_nxt = data[0];
      end else if (addr inside {[ADDR_CART_LO:ADDR_CART_HI]}) begin
        q_entry.kind   = OP_CART_WR;
        q_entry.addr_a = cart_idx[15:0];
      end else if (addr inside {[ADDR_ECHO_LO_LO:ADDR_ECHO_LO_HI]}) begin
        q_entry.kind   = OP_ECHO_WR;
        q_entry.addr_b = addr + ECHO_OFFSET;
      end else if (addr inside {[ADDR_ECHO_HI_LO:ADDR_ECHO_HI_HI]}) begin
        q_entry.kind   = OP_ECHO_WR;
        q_entry.addr_b = addr - ECHO_OFFSET;
      end else if (addr == ADDR_DIV || addr == ADDR_LY) begin
        q_entry.kind = OP_MEM_WR;
        q_entry.data = 8'd0;
      end else if (addr == ADDR_DMA) begin
        q_entry.kind = OP_DMA;
      end else begin
        q_entry.kind = OP_MEM_WR;
      end
    end else begin
      if (addr <= ADDR_ROM0_HI) begin
        q_entry.kind        = OP_ROM;
        q_entry.rom_address = {6'd0, addr};
      end else if (addr <= ADDR_ROM_HI) begin
        q_entry.kind        = OP_ROM;
        q_entry.rom_address = {rom_bank_r, addr[13:0]};
      end else if (addr inside {[ADDR_CART_LO:ADDR_CART_HI]}) begin
        q_entry.kind   = OP_CART_RD;
        q_entry.addr_a = cart_idx[15:0];
      end else begin
        q_entry.kind = OP_MEM_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r     <= 8'd1;
      ram_bank_r     <= 2'd0;
      ram_enable_r   <= 1'b0;
      banking_mode_r <= 1'b0;
    end else if (q_push) begin
      rom_bank_r     <= rom_bank_nxt;
      ram_bank_r     <= ram_bank_nxt;
      ram_enable_r   <= ram_enable_nxt;
      banking_mode_r <= banking_mode_nxt;
    end
  end

endmodule : bmmc_front

`default_nettype wire

// ===== sv/bmmc_queue.sv =====
// ----------------------------------------------------------------------------
// bmmc_queue
// short first-in first-out queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module bmmc_queue
  import bmmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output q_entry_t      head_entry
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  q_entry_t         entries_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule : bmmc_queue

`default_nettype wire

// ===== sv/bmmc_back.sv =====
// ----------------------------------------------------------------------------
// bmmc_back
// carries out queued accesses on the mapped memory and cartridge ram
// ----------------------------------------------------------------------------
`default_nettype none

module bmmc_back
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BYTES = CART_RAM_BYTES_DEF,
  parameter int DMA_LENGTH     = DMA_LENGTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire q_entry_t q_entry,
  output logic          q_pop,
  output logic          clr_busy,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int MAW = $clog2(MAP_BYTES);
  localparam int CAW = $clog2(CART_RAM_BYTES);
  localparam int DCW = $clog2(DMA_LENGTH + 1);
  localparam logic [DCW-1:0] DMA_END = DCW'(DMA_LENGTH);
  localparam logic [16:0]    CART_END = 17'(CART_RAM_BYTES);

  back_state_t    state_r, state_nxt;
  logic [MAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [DCW-1:0] dma_cnt_r, dma_cnt_nxt;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic           slot_free;
  logic           load_out;
  out_item_t      load_val;

  logic           mem_we, mem_re;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           cart_we, cart_re;
  logic [CAW-1:0] cart_waddr, cart_raddr;
  logic [7:0]     cart_wdata, cart_rdata;
  logic [15:0]    dma_src_base;

  assign slot_free    = !out_valid_r || out_ready;
  assign clr_busy     = (state_r == BK_CLEAR);
  assign dma_src_base = {q_entry.data, 8'h00};

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    dma_cnt_nxt = dma_cnt_r;
    case (state_r)
      BK_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        dma_cnt_nxt = '0;
        if (q_valid && slot_free) begin
          case (q_entry.kind)
            OP_MEM_RD, OP_CART_RD: state_nxt = BK_READ;
            OP_ECHO_WR:            state_nxt = BK_ECHO;
            OP_DMA:                state_nxt = BK_DMA;
            default:               state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_READ, BK_ECHO: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DMA: begin
        if (dma_cnt_r != DMA_END) begin
          dma_cnt_nxt = dma_cnt_r + 1'b1;
        end else if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = q_entry.addr_a;
    mem_wdata  = q_entry.data;
    mem_re     = 1'b0;
    mem_raddr  = q_entry.addr_a;
    cart_we    = 1'b0;
    cart_waddr = q_entry.addr_a[CAW-1:0];
    cart_wdata = q_entry.data;
    cart_re    = 1'b0;
    cart_raddr = q_entry.addr_a[CAW-1:0];
    q_pop      = 1'b0;
    load_out   = 1'b0;
    load_val   = '0;
    case (state_r)
      BK_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_cnt_r;
        mem_wdata  = 8'd0;
        cart_we    = ({1'b0, clr_cnt_r} < CART_END);
        cart_waddr = clr_cnt_r[CAW-1:0];
        cart_wdata = 8'd0;
      end
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          case (q_entry.kind)
            OP_ROM: begin
              load_out             = 1'b1;
              load_val.rom_fetch   = 1'b1;
              load_val.rom_address = q_entry.rom_address;
              q_pop                = 1'b1;
            end
            OP_MEM_WR: begin
              mem_we   = 1'b1;
              load_out = 1'b1;
              q_pop    = 1'b1;
            end
            OP_CART_WR: begin
              cart_we  = 1'b1;
              load_out = 1'b1;
              q_pop    = 1'b1;
            end
            OP_MEM_RD:  mem_re = 1'b1;
            OP_CART_RD: cart_re = 1'b1;
            OP_ECHO_WR: mem_we = 1'b1;
            OP_DMA: begin
            end
            default: begin
              load_out = 1'b1;
              q_pop    = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        if (slot_free) begin
          load_out           = 1'b1;
          load_val.read_data = (q_entry.kind == OP_CART_RD) ? cart_rdata : mem_rdata;
          q_pop              = 1'b1;
        end
      end
      BK_ECHO: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_waddr = q_entry.addr_b;
          load_out  = 1'b1;
          q_pop     = 1'b1;
        end
      end
      BK_DMA: begin
        // read of byte n overlaps the write of byte n-1
        mem_re    = (dma_cnt_r != DMA_END);
        mem_raddr = dma_src_base + 16'(dma_cnt_r);
        mem_we    = (dma_cnt_r != '0);
        mem_waddr = DMA_DEST + 16'(DCW'(dma_cnt_r - 1'b1));
        mem_wdata = mem_rdata;
        if (dma_cnt_r == DMA_END && slot_free) begin
          load_out = 1'b1;
          q_pop    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      dma_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      dma_cnt_r   <= dma_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= load_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bmmc_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmmc_ram #(
    .WIDTH (8),
    .DEPTH (CART_RAM_BYTES)
  ) u_cart_ram (
    .clk   (clk),
    .we    (cart_we),
    .waddr (cart_waddr),
    .wdata (cart_wdata),
    .re    (cart_re),
    .raddr (cart_raddr),
    .rdata (cart_rdata)
  );

endmodule : bmmc_back

`default_nettype wire
